/* hdl/ssit_pkg.sv */
// Shared constants, codes and structs for the sorted stream id table.
// Used by ssit_cell and sorted_stream_id_table_unit; depends on nothing.
`default_nettype none
package ssit_pkg;

  // Table geometry
  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int ID_BITS     = 31;
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_BITS = 7;

  // Request commands
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_MISS = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_UPD  = 1'b1
  } state_t;

  // Where a cell takes its next contents from
  typedef enum logic [1:0] {
    SEL_KEEP  = 2'd0,
    SEL_NEW   = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } cell_sel_t;

  // Controller to cell
  typedef struct packed {
    logic      cmp_en;
    logic      occ;
    cell_sel_t sel;
  } cell_ctrl_t;

  // Cell to controller, registered compare results
  typedef struct packed {
    logic lt;
    logic eq;
    logic hm;
  } cell_flags_t;

endpackage
`default_nettype wire

/* hdl/ssit_cell.sv */
// One table slot: holds a (stream id, handle) entry and its compare flags.
// Depends on ssit_pkg; neighbors are wired by the top level.
`default_nettype none
module ssit_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ssit_pkg::cell_ctrl_t            ctrl,
  input  wire logic [ssit_pkg::ID_BITS-1:0]     cmp_id,
  input  wire logic [ssit_pkg::HANDLE_BITS-1:0] cmp_hdl,
  input  wire logic [ssit_pkg::ID_BITS-1:0]     new_id,
  input  wire logic [ssit_pkg::HANDLE_BITS-1:0] new_hdl,
  input  wire logic [ssit_pkg::ID_BITS-1:0]     left_id,
  input  wire logic [ssit_pkg::HANDLE_BITS-1:0] left_hdl,
  input  wire logic [ssit_pkg::ID_BITS-1:0]     right_id,
  input  wire logic [ssit_pkg::HANDLE_BITS-1:0] right_hdl,
  output logic [ssit_pkg::ID_BITS-1:0]          id_o,
  output logic [ssit_pkg::HANDLE_BITS-1:0]      hdl_o,
  output ssit_pkg::cell_flags_t                 flags_o
);

  logic [ssit_pkg::ID_BITS-1:0]     id_r, id_nxt;
  logic [ssit_pkg::HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  ssit_pkg::cell_flags_t            flags_r, flags_nxt;

  // compare against the incoming request, only occupied slots count
  always_comb begin
    flags_nxt = flags_r;
    if (ctrl.cmp_en) begin
      flags_nxt.lt = ctrl.occ && (id_r < cmp_id);
      flags_nxt.eq = ctrl.occ && (id_r == cmp_id);
      flags_nxt.hm = ctrl.occ && (hdl_r == cmp_hdl);
    end
  end

  // shift / load select
  always_comb begin
    case (ctrl.sel)
      ssit_pkg::SEL_KEEP: begin
        id_nxt  = id_r;
        hdl_nxt = hdl_r;
      end
      ssit_pkg::SEL_NEW: begin
        id_nxt  = new_id;
        hdl_nxt = new_hdl;
      end
      ssit_pkg::SEL_LEFT: begin
        id_nxt  = left_id;
        hdl_nxt = left_hdl;
      end
      ssit_pkg::SEL_RIGHT: begin
        id_nxt  = right_id;
        hdl_nxt = right_hdl;
      end
      default: begin
        id_nxt  = id_r;
        hdl_nxt = hdl_r;
      end
    endcase
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    hdl_r <= hdl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign id_o    = id_r;
  assign hdl_o   = hdl_r;
  assign flags_o = flags_r;

endmodule
`default_nettype wire

/* hdl/sorted_stream_id_table_unit.sv */
// Top level of the sorted stream id table: controller plus a row of cells.
// Depends on ssit_pkg and ssit_cell.
//
// Usage:
//   A request (in_command, in_stream_id, in_handle) is taken at a rising edge
//   where start is high and busy is low. Commands: add, lookup by id, remove
//   by handle, clear. Entries stay sorted by id in a row of CAPACITY cells.
//   In the accept cycle every cell compares its entry with the request and
//   registers the outcome; in the next cycle (busy high) the controller
//   decides and every cell holds, loads the new entry, or shifts from a
//   neighbor, all in parallel. The result (out_found, out_handle_out,
//   out_entry_count, out_status) is shown with out_valid for exactly one
//   cycle; it is registered at the end of the update cycle. The receiver
//   cannot hold it off. Each request takes the compare cycle followed by the
//   shift cycle of the cell row, and no new request is taken while busy; a
//   new one can be taken in the same cycle that the previous result is shown.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; cell contents are left as they are and never read until written.
`default_nettype none
module sorted_stream_id_table_unit (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic [1:0]                                in_command,
  input  wire logic [ssit_pkg::ID_BITS-1:0]               in_stream_id,
  input  wire logic [ssit_pkg::HANDLE_BITS-1:0]           in_handle,
  output logic                                           out_valid,
  output logic                                           out_found,
  output logic [ssit_pkg::HANDLE_BITS-1:0]                out_handle_out,
  output logic [ssit_pkg::ENTRY_COUNT_BITS-1:0]           out_entry_count,
  output logic [1:0]                                     out_status
);

  localparam int CAP = ssit_pkg::CAPACITY;
  localparam int HB  = ssit_pkg::HANDLE_BITS;
  localparam int IB  = ssit_pkg::ID_BITS;
  localparam int CB  = ssit_pkg::CNT_BITS;

  ssit_pkg::state_t state_r, state_nxt;
  logic [CB-1:0]    count_r, count_nxt;
  ssit_pkg::cmd_t   cmd_r;
  logic [IB-1:0]    key_r;
  logic [HB-1:0]    hkey_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [HB-1:0]    out_hdl_r, out_hdl_nxt;
  ssit_pkg::status_t out_status_r, out_status_nxt;

  logic accept;

  // cell row wiring
  logic [IB-1:0]         id_w  [CAP];
  logic [HB-1:0]         hdl_w [CAP];
  ssit_pkg::cell_flags_t flg_w [CAP];
  logic [CAP:0]          eq_any;     // running OR of id matches
  logic [CAP:0]          hm_pre;     // running OR of handle matches
  logic [HB-1:0]         lk_hdl [CAP+1];

  logic dup, full, ins_ok, rm_hit;
  logic is_add, is_rm;

  assign accept = start && (state_r == ssit_pkg::ST_IDLE);
  assign busy   = (state_r == ssit_pkg::ST_UPD);

  assign is_add = (state_r == ssit_pkg::ST_UPD) && (cmd_r == ssit_pkg::CMD_ADD);
  assign is_rm  = (state_r == ssit_pkg::ST_UPD) && (cmd_r == ssit_pkg::CMD_REMOVE);
  assign dup    = eq_any[CAP];
  assign full   = (count_r == CB'(CAP));
  assign ins_ok = is_add && !dup && !full;
  assign rm_hit = hm_pre[CAP];

  assign eq_any[0] = 1'b0;
  assign hm_pre[0] = 1'b0;
  assign lk_hdl[0] = '0;

  // cell row
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic lt_left;
    logic [IB-1:0] l_id, r_id;
    logic [HB-1:0] l_hdl, r_hdl;
    ssit_pkg::cell_ctrl_t ctl;

    if (i == 0) begin : g_first
      assign lt_left = 1'b1;
      assign l_id    = key_r;
      assign l_hdl   = hkey_r;
    end else begin : g_mid
      assign lt_left = flg_w[i-1].lt;
      assign l_id    = id_w[i-1];
      assign l_hdl   = hdl_w[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign r_id  = id_w[i];
      assign r_hdl = hdl_w[i];
    end else begin : g_inner
      assign r_id  = id_w[i+1];
      assign r_hdl = hdl_w[i+1];
    end

    assign eq_any[i+1] = eq_any[i] | flg_w[i].eq;
    assign hm_pre[i+1] = hm_pre[i] | flg_w[i].hm;
    assign lk_hdl[i+1] = lk_hdl[i] | (flg_w[i].eq ? hdl_w[i] : '0);

    // per-cell control: insert opens a gap at the first slot not below key,
    // remove pulls in from the right from the first matching handle on
    always_comb begin
      ctl.cmp_en = accept;
      ctl.occ    = (CB'(i) < count_r);
      ctl.sel    = ssit_pkg::SEL_KEEP;
      if (ins_ok && !flg_w[i].lt) begin
        ctl.sel = lt_left ? ssit_pkg::SEL_NEW : ssit_pkg::SEL_LEFT;
      end else if (is_rm && hm_pre[i+1]) begin
        ctl.sel = ssit_pkg::SEL_RIGHT;
      end
    end

    ssit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctl),
      .cmp_id    (in_stream_id),
      .cmp_hdl   (in_handle),
      .new_id    (key_r),
      .new_hdl   (hkey_r),
      .left_id   (l_id),
      .left_hdl  (l_hdl),
      .right_id  (r_id),
      .right_hdl (r_hdl),
      .id_o      (id_w[i]),
      .hdl_o     (hdl_w[i]),
      .flags_o   (flg_w[i])
    );
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= ssit_pkg::cmd_t'(in_command);
      key_r  <= in_stream_id;
      hkey_r <= in_handle;
    end
  end

  // state and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssit_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_hdl_r    <= out_hdl_nxt;
    out_status_r <= out_status_nxt;
  end

  // next state, count and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found_r;
    out_hdl_nxt    = out_hdl_r;
    out_status_nxt = out_status_r;
    case (state_r)
      ssit_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ssit_pkg::ST_UPD;
        end
      end
      ssit_pkg::ST_UPD: begin
        state_nxt      = ssit_pkg::ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b0;
        out_hdl_nxt    = '0;
        out_status_nxt = ssit_pkg::STS_DONE;
        case (cmd_r)
          ssit_pkg::CMD_ADD: begin
            if (dup) begin
              out_status_nxt = ssit_pkg::STS_DUP;
            end else if (full) begin
              out_status_nxt = ssit_pkg::STS_FULL;
            end else begin
              count_nxt = count_r + CB'(1);
            end
          end
          ssit_pkg::CMD_LOOKUP: begin
            if (dup) begin
              out_found_nxt = 1'b1;
              out_hdl_nxt   = lk_hdl[CAP];
            end else begin
              out_status_nxt = ssit_pkg::STS_MISS;
            end
          end
          ssit_pkg::CMD_REMOVE: begin
            if (rm_hit) begin
              out_found_nxt = 1'b1;
              out_hdl_nxt   = hkey_r;
              count_nxt     = count_r - CB'(1);
            end else begin
              out_status_nxt = ssit_pkg::STS_MISS;
            end
          end
          ssit_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
      default: begin
        state_nxt = ssit_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_handle_out  = out_hdl_r;
  assign out_entry_count = ssit_pkg::ENTRY_COUNT_BITS'(count_r);
  assign out_status      = out_status_r;

  // checks
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("update phase longer than one cycle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CB'(CAP))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |=> out_valid)
    else $error("result missing after update");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ssit_pkg::STS_FULL) |-> full)
    else $error("full reported below capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ssit_pkg::STS_DONE))
    else $error("found with non-done status");

endmodule
`default_nettype wire
